// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Each macro samples on clk and is disabled while arst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bba_pkg.sv -----
// Shared constants, types and codes for the bitmap block allocator.
// Has no dependencies; every allocator module refers to it by scoped names.
package bba_pkg;

	// Sizing of the store.
	localparam int BLOCK_BYTES     = 4096;
	localparam int NUM_SLOTS       = 32;
	localparam int MAX_FILE_BLOCKS = 16;
	localparam int NUM_BLOCKS      = 256;

	// Port field widths.
	localparam int SLOT_W   = 5;
	localparam int SIZE_W   = 17;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 5;
	localparam int FREE_W   = 9;

	// Derived widths. A block size is a power of two, so rounding up is an add and a shift.
	localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int NEED_W      = SIZE_W + 1 - BLOCK_SHIFT;
	localparam int BLK_W       = $clog2(NUM_BLOCKS);
	localparam int SCAN_W      = 8;
	localparam int OFF_W       = $clog2(SCAN_W);
	localparam int NUM_WORDS   = NUM_BLOCKS / SCAN_W;
	localparam int WORD_W      = $clog2(NUM_WORDS);
	localparam int LIST_DEPTH  = NUM_SLOTS * MAX_FILE_BLOCKS;
	localparam int LIST_AW     = $clog2(LIST_DEPTH);

	// Result codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_SPACE = 2'd1,
		STATUS_TOO_BIG  = 2'd2
	} status_e_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_GROW,
		S_SHRINK_RD,
		S_SHRINK_WR,
		S_REPORT
	} state_e_t;

	// One bitmap update per cycle: set a block, clear a block, or neither.
	typedef struct packed {
		logic             set;
		logic             clr;
		logic [BLK_W-1:0] idx;
	} bm_cmd_t;

endpackage

// ----- rtl/core/bitmap_block_allocator.sv -----
// Top level of the bitmap first-fit block allocator: sequencer, slot tables and free count.
// Depends on bba_pkg, bba_find, bba_bitmap, bba_list_mem and assert_macros.svh.
//
//   Channel   Signals                                   Direction  Transfer when
//   request   start, busy, slot, new_size               in         start && !busy at a clock edge
//   result    done, status, block_count, free_blocks    out        done high for one cycle
//
// A request loads the slot tables in S_LOAD and reports its result in S_REPORT.
// Growth scans the bitmap one 8-block word per cycle through the finder, except that it
// stays on a word while it appends the free blocks found in it.
// Shrinking releases each block in a read state and a write state, as the list memory's read port is registered.
// Reset clears the bitmap and slot tables at once; no clearing pass is needed.
// The receiver cannot stall results, and busy stays high from transfer until done.
`include "assert_macros.svh"

module bitmap_block_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bba_pkg::SLOT_W-1:0]   slot,
	input  logic [bba_pkg::SIZE_W-1:0]   new_size,
	output logic                         done,
	output logic [bba_pkg::STATUS_W-1:0] status,
	output logic [bba_pkg::CNT_W-1:0]    block_count,
	output logic [bba_pkg::FREE_W-1:0]   free_blocks
);

	bba_pkg::state_e_t  state_q, state_d;
	bba_pkg::status_e_t status_q;

	logic [bba_pkg::SLOT_W-1:0] slot_q;
	logic [bba_pkg::SIZE_W-1:0] size_q;
	logic [bba_pkg::FREE_W-1:0] free_q;
	logic [bba_pkg::SIZE_W-1:0] byte_size_q [bba_pkg::NUM_SLOTS];
	logic [bba_pkg::CNT_W-1:0]  held_q [bba_pkg::NUM_SLOTS];
	logic [bba_pkg::CNT_W-1:0]  pos_q;
	logic [bba_pkg::CNT_W-1:0]  need_q;
	logic [bba_pkg::WORD_W-1:0] word_q;
	logic [bba_pkg::OFF_W-1:0]  off_q;

	logic [bba_pkg::SIZE_W-1:0] cur_size;
	logic [bba_pkg::CNT_W-1:0]  cur_held;
	logic [bba_pkg::SIZE_W:0]   round_sum;
	logic [bba_pkg::NEED_W-1:0] need_w;
	logic [bba_pkg::FREE_W-1:0] need_ext;
	logic [bba_pkg::FREE_W-1:0] have_ext;
	logic                       grow_req;
	logic                       shrink_req;
	logic                       too_big;
	logic                       no_space;

	logic [bba_pkg::SCAN_W-1:0]  map_word;
	logic [bba_pkg::WORD_W-1:0]  map_word_idx;
	logic                        found;
	logic [bba_pkg::OFF_W-1:0]   found_bit;
	logic [bba_pkg::OFF_W:0]     off_next;
	logic [bba_pkg::CNT_W-1:0]   pos_inc;
	logic [bba_pkg::CNT_W-1:0]   pos_dec;
	logic                        last_word;
	bba_pkg::bm_cmd_t            bm_cmd;

	logic [bba_pkg::LIST_AW-1:0] list_base;
	logic [bba_pkg::LIST_AW-1:0] list_wr_addr;
	logic [bba_pkg::LIST_AW-1:0] list_rd_addr;
	logic [bba_pkg::BLK_W-1:0]   list_rd_data;
	logic                        list_wr_en;
	logic                        list_rd_en;
	logic                        rel_used;

	// Current slot state and the rounded-up block count of the requested size.
	assign cur_size   = byte_size_q[slot_q];
	assign cur_held   = held_q[slot_q];
	assign round_sum  = {1'b0, size_q} + (bba_pkg::SIZE_W + 1)'(bba_pkg::BLOCK_BYTES - 1);
	assign need_w     = bba_pkg::NEED_W'(round_sum >> bba_pkg::BLOCK_SHIFT);
	assign need_ext   = bba_pkg::FREE_W'(need_w);
	assign have_ext   = bba_pkg::FREE_W'(cur_held);
	assign grow_req   = size_q > cur_size;
	assign shrink_req = size_q < cur_size;
	assign too_big    = need_w > bba_pkg::NEED_W'(bba_pkg::MAX_FILE_BLOCKS);
	assign no_space   = (need_ext > have_ext) && ((need_ext - have_ext) > free_q);

	// The bitmap read port is shared by the scan and by releases; the finder looks at one word per cycle.
	assign map_word_idx = (state_q == bba_pkg::S_GROW) ? word_q
		: list_rd_data[bba_pkg::BLK_W-1:bba_pkg::OFF_W];

	bba_bitmap u_bitmap (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (bm_cmd),
		.rd_word_idx (map_word_idx),
		.rd_word     (map_word)
	);

	bba_find u_find (
		.word    (map_word),
		.off     (off_q),
		.found   (found),
		.bit_idx (found_bit)
	);

	assign off_next  = {1'b0, found_bit} + (bba_pkg::OFF_W + 1)'(1);
	assign pos_inc   = pos_q + bba_pkg::CNT_W'(1);
	assign pos_dec   = pos_q - bba_pkg::CNT_W'(1);
	assign last_word = word_q == bba_pkg::WORD_W'(bba_pkg::NUM_WORDS - 1);
	assign rel_used  = map_word[list_rd_data[bba_pkg::OFF_W-1:0]];

	// Block list addressing: the slot's base plus the position being written or released.
	assign list_base    = bba_pkg::LIST_AW'(slot_q) *
		bba_pkg::LIST_AW'(bba_pkg::MAX_FILE_BLOCKS);
	assign list_wr_addr = list_base + bba_pkg::LIST_AW'(pos_q);
	assign list_rd_addr = list_base + bba_pkg::LIST_AW'(pos_dec);
	assign list_wr_en   = (state_q == bba_pkg::S_GROW) && found;
	assign list_rd_en   = state_q == bba_pkg::S_SHRINK_RD;

	bba_list_mem u_list (
		.clk     (clk),
		.wr_en   (list_wr_en),
		.wr_addr (list_wr_addr),
		.wr_data ({word_q, found_bit}),
		.rd_en   (list_rd_en),
		.rd_addr (list_rd_addr),
		.rd_data (list_rd_data)
	);

	// Bitmap updates: mark an appended block, or release a trailing one.
	always_comb begin
		bm_cmd.set = list_wr_en;
		bm_cmd.clr = (state_q == bba_pkg::S_SHRINK_WR) && rel_used;
		bm_cmd.idx = (state_q == bba_pkg::S_GROW) ? {word_q, found_bit} : list_rd_data;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			bba_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = bba_pkg::S_LOAD;
				end
			end
			bba_pkg::S_LOAD: begin
				state_d = bba_pkg::S_REPORT;
				if (grow_req && !too_big && !no_space && (need_ext > have_ext)) begin
					state_d = bba_pkg::S_GROW;
				end else if (shrink_req && (have_ext > need_ext)) begin
					state_d = bba_pkg::S_SHRINK_RD;
				end
			end
			bba_pkg::S_GROW: begin
				if (found ? (pos_inc == need_q) : last_word) begin
					state_d = bba_pkg::S_REPORT;
				end
			end
			bba_pkg::S_SHRINK_RD: begin
				state_d = bba_pkg::S_SHRINK_WR;
			end
			bba_pkg::S_SHRINK_WR: begin
				state_d = (pos_dec == need_q) ? bba_pkg::S_REPORT : bba_pkg::S_SHRINK_RD;
			end
			bba_pkg::S_REPORT: begin
				done    = 1'b1;
				state_d = bba_pkg::S_IDLE;
			end
			default: begin
				state_d = bba_pkg::S_IDLE;
			end
		endcase
	end

	// Request capture and per-request working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			bba_pkg::S_IDLE: begin
				slot_q <= slot;
				size_q <= new_size;
			end
			bba_pkg::S_LOAD: begin
				pos_q  <= cur_held;
				need_q <= bba_pkg::CNT_W'(need_w);
				word_q <= '0;
				off_q  <= '0;
				if (grow_req && too_big) begin
					status_q <= bba_pkg::STATUS_TOO_BIG;
				end else if (grow_req && no_space) begin
					status_q <= bba_pkg::STATUS_NO_SPACE;
				end else begin
					status_q <= bba_pkg::STATUS_OK;
				end
			end
			bba_pkg::S_GROW: begin
				if (found) begin
					pos_q <= pos_inc;
					off_q <= off_next[bba_pkg::OFF_W-1:0];
					if (off_next[bba_pkg::OFF_W]) begin
						word_q <= word_q + bba_pkg::WORD_W'(1);
					end
				end else begin
					off_q  <= '0;
					word_q <= word_q + bba_pkg::WORD_W'(1);
				end
			end
			bba_pkg::S_SHRINK_WR: begin
				pos_q <= pos_dec;
			end
			default: begin
			end
		endcase
	end

	// Free count and slot tables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= bba_pkg::FREE_W'(bba_pkg::NUM_BLOCKS);
			for (int s = 0; s < bba_pkg::NUM_SLOTS; s++) begin
				byte_size_q[s] <= '0;
				held_q[s]      <= '0;
			end
		end else begin
			case (state_q)
				bba_pkg::S_LOAD: begin
					if ((grow_req && !too_big && !no_space) || shrink_req) begin
						byte_size_q[slot_q] <= size_q;
					end
				end
				bba_pkg::S_GROW: begin
					if (found) begin
						free_q <= free_q - bba_pkg::FREE_W'(1);
						if (pos_inc == need_q) begin
							held_q[slot_q] <= pos_inc;
						end
					end else if (last_word) begin
						held_q[slot_q] <= pos_q;
					end
				end
				bba_pkg::S_SHRINK_WR: begin
					if (rel_used) begin
						free_q <= free_q + bba_pkg::FREE_W'(1);
					end
					if (pos_dec == need_q) begin
						held_q[slot_q] <= need_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result ports, valid while done is high.
	assign status      = status_q;
	assign block_count = cur_held;
	assign free_blocks = free_q;

	// Checks on the sequencer and the free count.
	`ASSERT_SAME(a_free_range, 1'b1,
		free_q <= bba_pkg::FREE_W'(bba_pkg::NUM_BLOCKS), "free count above store size")
	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`ASSERT_NEXT(a_done_idle, done, !busy, "block still busy after reporting")
	`ASSERT_NEXT(a_free_idle, !busy, $stable(free_q), "free count moved while idle")
	`ASSERT_SAME(a_grow_bound, state_q == bba_pkg::S_GROW, pos_q < need_q,
		"growth ran past the needed count")

endmodule

// ----- rtl/core/bba_find.sv -----
// Lowest free block finder over one bitmap word, at or above a starting offset.
// Depends on bba_pkg for the word and offset widths.
module bba_find (
	input  logic [bba_pkg::SCAN_W-1:0] word,
	input  logic [bba_pkg::OFF_W-1:0]  off,
	output logic                       found,
	output logic [bba_pkg::OFF_W-1:0]  bit_idx
);

	// Walk from the top bit down so that the lowest qualifying bit wins.
	always_comb begin
		found   = 1'b0;
		bit_idx = '0;
		for (int i = bba_pkg::SCAN_W - 1; i >= 0; i--) begin
			if (!word[i] && (bba_pkg::OFF_W'(i) >= off)) begin
				found   = 1'b1;
				bit_idx = bba_pkg::OFF_W'(i);
			end
		end
	end

endmodule

// ----- rtl/core/bba_bitmap.sv -----
// Used-block bitmap, held as words of flip-flops that reset clears to all free.
// Depends on bba_pkg for sizing and the update command struct.
module bba_bitmap (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bba_pkg::bm_cmd_t           cmd,
	input  logic [bba_pkg::WORD_W-1:0] rd_word_idx,
	output logic [bba_pkg::SCAN_W-1:0] rd_word
);

	logic [bba_pkg::SCAN_W-1:0] map_q [bba_pkg::NUM_WORDS];
	logic [bba_pkg::WORD_W-1:0] cmd_word;
	logic [bba_pkg::OFF_W-1:0]  cmd_bit;

	assign cmd_word = cmd.idx[bba_pkg::BLK_W-1:bba_pkg::OFF_W];
	assign cmd_bit  = cmd.idx[bba_pkg::OFF_W-1:0];

	// Set or clear a single block per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < bba_pkg::NUM_WORDS; w++) begin
				map_q[w] <= '0;
			end
		end else if (cmd.set) begin
			map_q[cmd_word][cmd_bit] <= 1'b1;
		end else if (cmd.clr) begin
			map_q[cmd_word][cmd_bit] <= 1'b0;
		end
	end

	// One word is read per cycle, either for the scan or for a release.
	assign rd_word = map_q[rd_word_idx];

endmodule

// ----- rtl/core/bba_list_mem.sv -----
// Block list memory: one entry per slot and position, written and read at one port each.
// Depends on bba_pkg for depth and widths. Contents are undefined until written.
module bba_list_mem (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [bba_pkg::LIST_AW-1:0] wr_addr,
	input  logic [bba_pkg::BLK_W-1:0]   wr_data,
	input  logic                        rd_en,
	input  logic [bba_pkg::LIST_AW-1:0] rd_addr,
	output logic [bba_pkg::BLK_W-1:0]   rd_data
);

	logic [bba_pkg::BLK_W-1:0] mem_q [bba_pkg::LIST_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
